FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/gsap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor ppm package
// Field widths, register codes, reset values and the fractional power table.
// ----------------------------------------------------------------------------
package gsap_pkg;

	localparam int ADC_W      = 12;
	localparam int AVG_W      = 16;
	localparam int PPM_W      = 26;
	localparam int LPC_W      = 24;
	localparam int LAZ_W      = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int LIN_W      = AVG_W + LPC_W;
	localparam int X_W        = 25;
	localparam int L2_W       = 22;
	localparam int Y_W        = X_W + L2_W;
	localparam int EXP_W      = Y_W - 32;
	localparam int ACC_W      = 31;
	localparam int FRAC_STEPS = 12;
	localparam int STEP_W     = 4;
	localparam int SHIFT_W    = ACC_W + PPM_W - 1;

	localparam logic [1:0] REG_ZERO_POINT    = 2'd0;
	localparam logic [1:0] REG_LOG_PER_COUNT = 2'd1;
	localparam logic [1:0] REG_LOG_AT_ZERO   = 2'd2;

	localparam logic [AVG_W-1:0] ZERO_POINT_RST    = 16'd43610;
	localparam logic [LPC_W-1:0] LOG_PER_COUNT_RST = 24'd31972;
	localparam logic [LAZ_W-1:0] LOG_AT_ZERO_RST   = 16'd10658;

	localparam logic [L2_W-1:0]  LOG2_10_Q20 = 22'd3483294;
	localparam logic [ACC_W-1:0] ONE_Q30     = 31'd1073741824;
	localparam logic [PPM_W-1:0] PPM_MAX     = 26'd67108863;
	localparam logic [EXP_W-1:0] EXP_LIMIT   = 15'd26;

	typedef struct packed {
		logic [AVG_W-1:0] zero_point;
		logic [LPC_W-1:0] log_per_count;
		logic [LAZ_W-1:0] log_at_zero;
	} cfg_t;

	// 2^(2^-(idx+1)) in Q1.30
	function automatic logic [ACC_W-1:0] pow2_frac(input logic [STEP_W-1:0] idx);
		logic [ACC_W-1:0] v;
		unique case (idx)
			4'd0:    v = 31'd1518500250;
			4'd1:    v = 31'd1276901417;
			4'd2:    v = 31'd1170923762;
			4'd3:    v = 31'd1121280436;
			4'd4:    v = 31'd1097253708;
			4'd5:    v = 31'd1085434106;
			4'd6:    v = 31'd1079572136;
			4'd7:    v = 31'd1076653033;
			4'd8:    v = 31'd1075196443;
			4'd9:    v = 31'd1074468889;
			4'd10:   v = 31'd1074105294;
			4'd11:   v = 31'd1073923544;
			default: v = ONE_Q30;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/gsap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor ppm channels
// Valid/ready channels for raw samples and for converted results.
// ----------------------------------------------------------------------------
interface gsap_sample_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface gsap_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] average_counts;
	logic [25:0] ppm;
	logic        below_range;

	modport source (output valid, output average_counts, output ppm, output below_range,
		input ready);
	modport sink   (input valid, input average_counts, input ppm, input below_range,
		output ready);
endinterface

FILE: sv/gsap_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor ppm front end
// Accumulates samples and hands each completed group sum to the queue.
// ----------------------------------------------------------------------------
module gsap_front #(
	parameter int SAMPLES  = 5,
	parameter int ADC_BITS = 12,
	parameter int SUM_W    = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	gsap_sample_if.sink        samples,
	output logic               push,
	output logic [SUM_W-1:0]   push_sum,
	input  logic               full
);
	import gsap_pkg::*;

	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);
	localparam logic [CNT_W-1:0] LAST_CNT    = CNT_W'(SAMPLES - 1);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [ADC_W-1:0] s;
	logic             last;
	logic             xfer;

	assign s        = samples.sample & SAMPLE_MASK;
	assign last     = (count_q == LAST_CNT);
	assign samples.ready = !(last && full);
	assign xfer     = samples.valid && samples.ready;
	assign push     = xfer && last;
	assign push_sum = sum_q + SUM_W'(s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (xfer) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= push_sum;
			end
		end
	end

endmodule

FILE: sv/gsap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor ppm group queue
// Two-entry FIFO of group sums between the front end and the converter.
// ----------------------------------------------------------------------------
module gsap_queue #(
	parameter int W = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign head  = mem_q[rd_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/gsap_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor ppm converter
// Sequencer that turns a group sum into average counts and ppm, one step a
// cycle, waiting in the last step for a free output, with a registered result.
// ----------------------------------------------------------------------------
module gsap_back #(
	parameter int SAMPLES = 5,
	parameter int SUM_W   = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gsap_pkg::cfg_t    cfg,
	input  logic [SUM_W-1:0]  head,
	input  logic              empty,
	output logic              pop,
	gsap_result_if.source     results
);
	import gsap_pkg::*;

	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
	localparam int NUM_W  = SUM_W + 4;
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int QUOT_W = PROD_W - RECIP_SH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_AVG  = 3'd1;
	localparam logic [2:0] ST_LIN  = 3'd2;
	localparam logic [2:0] ST_LOG  = 3'd3;
	localparam logic [2:0] ST_EXP  = 3'd4;
	localparam logic [2:0] ST_POW  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]              state_q;
	logic [PROD_W-1:0]       quot_q;
	logic [AVG_W-1:0]        avg_q;
	logic                    below_q;
	logic [AVG_W-1:0]        d_q;
	logic [LIN_W-1:0]        lin_q;
	logic [X_W-1:0]          x_q;
	logic [EXP_W-1:0]        n_q;
	logic [FRAC_STEPS-1:0]   frac_q;
	logic [ACC_W-1:0]        acc_q;
	logic [STEP_W-1:0]       step_q;
	logic                    out_valid_q;
	logic [AVG_W-1:0]        out_avg_q;
	logic [PPM_W-1:0]        out_ppm_q;
	logic                    out_below_q;

	logic [QUOT_W-1:0]       quot;
	logic [AVG_W-1:0]        avg;
	logic [Y_W-1:0]          y;
	logic [2*ACC_W-1:0]      pw_prod;
	logic [SHIFT_W-1:0]      shifted;
	logic [PPM_W-1:0]        ppm_val;
	logic                    load;

	assign pop     = (state_q == ST_IDLE) && !empty;
	assign quot    = quot_q[PROD_W-1:RECIP_SH];
	assign avg     = (|quot[QUOT_W-1:AVG_W]) ? '1 : quot[AVG_W-1:0];
	assign y       = x_q * LOG2_10_Q20;
	assign pw_prod = acc_q * pow2_frac(step_q);
	assign shifted = SHIFT_W'(acc_q) << n_q[4:0];
	assign load    = (state_q == ST_FIN) && (!out_valid_q || results.ready);

	always_comb begin
		priority if (below_q) begin
			ppm_val = '0;
		end else if (n_q >= EXP_LIMIT) begin
			ppm_val = PPM_MAX;
		end else begin
			ppm_val = shifted[SHIFT_W-1 -: PPM_W];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				quot_q <= {head, 4'b0000} * RECIP;
			end
			ST_AVG: begin
				avg_q   <= avg;
				below_q <= (avg >= cfg.zero_point);
				d_q     <= cfg.zero_point - avg;
			end
			ST_LIN: begin
				lin_q <= d_q * cfg.log_per_count;
			end
			ST_LOG: begin
				x_q <= X_W'(cfg.log_at_zero) + X_W'(lin_q[LIN_W-1:16]);
			end
			ST_EXP: begin
				n_q    <= y[Y_W-1:32];
				frac_q <= y[31:32-FRAC_STEPS];
				acc_q  <= ONE_Q30;
				step_q <= '0;
			end
			ST_POW: begin
				if (frac_q[FRAC_STEPS-1]) begin
					acc_q <= pw_prod[ACC_W+29:30];
				end
				frac_q <= frac_q << 1;
				step_q <= step_q + STEP_W'(1);
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
		if (load) begin
			out_avg_q   <= avg_q;
			out_ppm_q   <= ppm_val;
			out_below_q <= below_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!empty) state_q <= ST_AVG;
				ST_AVG: begin
					state_q <= (avg >= cfg.zero_point) ? ST_FIN : ST_LIN;
				end
				ST_LIN:  state_q <= ST_LOG;
				ST_LOG:  state_q <= ST_EXP;
				ST_EXP:  state_q <= ST_POW;
				ST_POW: begin
					if (step_q == STEP_W'(FRAC_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN:  if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid          = out_valid_q;
	assign results.average_counts = out_avg_q;
	assign results.ppm            = out_ppm_q;
	assign results.below_range    = out_below_q;

endmodule

FILE: sv/gas_sensor_average_to_ppm.sv
`timescale 1ns / 1ps
// Throughput: one sample a cycle, but a group's last sample waits while the
//   queue is full; the converter takes a new group only when done with the
//   last, skips the log and fractional power steps below range, and a
//   two-group queue absorbs bursts.
// Reset: arst_n clears the sum, count, queue, sequencer and registers to defaults.
// ----------------------------------------------------------------------------
// Gas sensor average to ppm
// Averages groups of ADC samples and converts each mean to a ppm reading.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gas_sensor_average_to_ppm #(
	parameter int SAMPLES  = 5,
	parameter int ADC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gsap_sample_if.sink                       samples,
	gsap_result_if.source                     results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gsap_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [gsap_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [gsap_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import gsap_pkg::*;

	localparam int SUM_W = ADC_W + $clog2(SAMPLES);

	logic [AVG_W-1:0] zero_point_q;
	logic [LPC_W-1:0] log_per_count_q;
	logic [LAZ_W-1:0] log_at_zero_q;
	cfg_t             cfg;
	logic [1:0]       reg_idx;
	logic             wr_en;
	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic             full;
	logic             empty;
	logic             pop;
	logic [SUM_W-1:0] head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_point_q    <= ZERO_POINT_RST;
			log_per_count_q <= LOG_PER_COUNT_RST;
			log_at_zero_q   <= LOG_AT_ZERO_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ZERO_POINT:    zero_point_q    <= pwdata[AVG_W-1:0];
				REG_LOG_PER_COUNT: log_per_count_q <= pwdata[LPC_W-1:0];
				REG_LOG_AT_ZERO:   log_at_zero_q   <= pwdata[LAZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ZERO_POINT:    prdata = CFG_DATA_W'(zero_point_q);
			REG_LOG_PER_COUNT: prdata = CFG_DATA_W'(log_per_count_q);
			REG_LOG_AT_ZERO:   prdata = CFG_DATA_W'(log_at_zero_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.zero_point    = zero_point_q;
	assign cfg.log_per_count = log_per_count_q;
	assign cfg.log_at_zero   = log_at_zero_q;

	gsap_front #(
		.SAMPLES  (SAMPLES),
		.ADC_BITS (ADC_BITS),
		.SUM_W    (SUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.push     (push),
		.push_sum (push_sum),
		.full     (full)
	);

	gsap_queue #(
		.W (SUM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_sum),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	gsap_back #(
		.SAMPLES (SAMPLES),
		.SUM_W   (SUM_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

	`ASSERT_SAME(a_no_push_when_full, push, !full)
	`ASSERT_SAME(a_below_gives_zero, results.valid && results.below_range, results.ppm == '0)
	`ASSERT_SAME(a_below_matches_cfg, results.valid,
		results.below_range == (results.average_counts >= zero_point_q))
	`ASSERT_NEXT(a_pop_leaves_room, pop && !push, !full)

endmodule

FILE: tb/sv/tb_gas_sensor_average_to_ppm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor average to ppm testbench
// Streams ADC samples in groups of five through gas_sensor_average_to_ppm with
// bursty input and a stalling result sink. The register set is rewritten
// between phases over the APB port, including the extreme settings. Each
// group mean is converted by a local fixed-point model, and every result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_gas_sensor_average_to_ppm;

	import gsap_pkg::*;

	localparam int GROUP_LEN    = 5;
	localparam int ADC_MAX      = 4095;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_GROUPS = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_SPACING = 700;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [AVG_W-1:0] average_counts;
		logic [PPM_W-1:0] ppm;
		logic             below_range;
	} ppm_reading_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE
	} sink_mode_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	gsap_sample_if smp_ch();
	gsap_result_if res_ch();

	gas_sensor_average_to_ppm #(
		.SAMPLES (GROUP_LEN),
		.ADC_BITS(ADC_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp_ch),
		.results(res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// model state
	logic [AVG_W-1:0] zero_pt;
	logic [LPC_W-1:0] slope;
	logic [LAZ_W-1:0] log_zero;
	logic [16:0]      group_sum;
	int               group_fill;

	logic [ADC_W-1:0] sample_queue[$];
	ppm_reading_t     expected_readings[$];

	int         error_count;
	int         xfer_count;
	int         cycle_count;
	int         burst_left;
	int         gap_left;
	int         hold_left;
	int         next_hold_at;
	int         mode_left;
	sink_mode_t sink_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [ACC_W-1:0] root_factor(input int idx);
		logic [ACC_W-1:0] f;
		case (idx)
			0:       f = 31'd1518500250;
			1:       f = 31'd1276901417;
			2:       f = 31'd1170923762;
			3:       f = 31'd1121280436;
			4:       f = 31'd1097253708;
			5:       f = 31'd1085434106;
			6:       f = 31'd1079572136;
			7:       f = 31'd1076653033;
			8:       f = 31'd1075196443;
			9:       f = 31'd1074468889;
			10:      f = 31'd1074105294;
			default: f = 31'd1073923544;
		endcase
		return f;
	endfunction

	function automatic ppm_reading_t convert_group(input logic [16:0] sum);
		ppm_reading_t    r;
		longint unsigned mean;
		longint unsigned expo;
		longint unsigned y;
		longint unsigned n;
		longint unsigned acc;
		longint unsigned val;
		logic [31:0]     frac;
		int              i;
		mean = sum;
		mean = (mean * 16) / GROUP_LEN;
		if (mean > 65535) begin
			mean = 65535;
		end
		r.average_counts = mean[AVG_W-1:0];
		r.below_range = (mean >= zero_pt);
		r.ppm = '0;
		if (!r.below_range) begin
			expo = log_zero;
			expo = expo + (((zero_pt - mean) * slope) >> 16);
			y = expo * LOG2_10_Q20;
			n = y >> 32;
			frac = y[31:0];
			if (n >= 26) begin
				r.ppm = PPM_MAX;
			end else begin
				acc = ONE_Q30;
				for (i = 0; i < FRAC_STEPS; i++) begin
					if (frac[31-i]) begin
						acc = (acc * root_factor(i)) >> 30;
					end
				end
				val = (acc << n) >> 30;
				r.ppm = (val > PPM_MAX) ? PPM_MAX : val[PPM_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic void accumulate_sample(input logic [ADC_W-1:0] s);
		group_sum = group_sum + s;
		group_fill = group_fill + 1;
		if (group_fill == GROUP_LEN) begin
			expected_readings.push_back(convert_group(group_sum));
			group_sum = '0;
			group_fill = 0;
		end
	endfunction

	// sender: bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
			smp_ch.sample <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (smp_ch.valid && smp_ch.ready) begin
				accumulate_sample(smp_ch.sample);
				xfer_count <= xfer_count + 1;
			end
			if (!smp_ch.valid || smp_ch.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					smp_ch.valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					smp_ch.valid <= 1'b1;
					smp_ch.sample <= sample_queue.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					smp_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long sink hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 500;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (xfer_count >= next_hold_at) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_SPACING;
		end
	end

	// sink stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_mode <= SINK_OPEN;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_OPEN: res_ch.ready <= 1'b1;
					SINK_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
					default:   res_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		ppm_reading_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result avg=%0d ppm=%0d below=%0b", $realtime,
					res_ch.average_counts, res_ch.ppm, res_ch.below_range);
				error_count++;
			end else begin
				want = expected_readings.pop_front();
				if (res_ch.average_counts !== want.average_counts) begin
					$display("%0t: average_counts expected %0d actual %0d", $realtime,
						want.average_counts, res_ch.average_counts);
					error_count++;
				end
				if (res_ch.ppm !== want.ppm) begin
					$display("%0t: ppm expected %0d actual %0d", $realtime,
						want.ppm, res_ch.ppm);
					error_count++;
				end
				if (res_ch.below_range !== want.below_range) begin
					$display("%0t: below_range expected %0b actual %0b", $realtime,
						want.below_range, res_ch.below_range);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ZERO_POINT:    zero_pt = data[AVG_W-1:0];
			REG_LOG_PER_COUNT: slope = data[LPC_W-1:0];
			REG_LOG_AT_ZERO:   log_zero = data[LAZ_W-1:0];
			default:           ;
		endcase
	endtask

	task automatic wait_drained();
		while (sample_queue.size() != 0 || smp_ch.valid || expected_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_group(input int a, input int b, input int c, input int d,
		input int e);
		sample_queue.push_back(a[ADC_W-1:0]);
		sample_queue.push_back(b[ADC_W-1:0]);
		sample_queue.push_back(c[ADC_W-1:0]);
		sample_queue.push_back(d[ADC_W-1:0]);
		sample_queue.push_back(e[ADC_W-1:0]);
	endtask

	task automatic plan_random_group();
		int kind;
		int center;
		int spread;
		int s;
		int k;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			center = zero_pt >> 4;
			spread = 3;
		end else begin
			center = $urandom_range(0, ADC_MAX);
			spread = $urandom_range(0, 64);
		end
		for (k = 0; k < GROUP_LEN; k++) begin
			if (kind >= 9) begin
				s = ($urandom_range(0, 1) != 0) ? ADC_MAX : 0;
			end else if (kind >= 7) begin
				s = $urandom_range(0, ADC_MAX);
			end else begin
				s = center + int'($urandom_range(0, 2 * spread)) - spread;
			end
			if (s < 0) begin
				s = 0;
			end
			if (s > ADC_MAX) begin
				s = ADC_MAX;
			end
			sample_queue.push_back(s[ADC_W-1:0]);
		end
	endtask

	initial begin
		int p;
		int g;
		int w;
		logic [CFG_DATA_W-1:0] lpc_bits;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_ch.valid = 1'b0;
		smp_ch.sample = '0;
		res_ch.ready = 1'b0;
		zero_pt = ZERO_POINT_RST;
		slope = LOG_PER_COUNT_RST;
		log_zero = LOG_AT_ZERO_RST;
		group_sum = '0;
		group_fill = 0;
		error_count = 0;
		xfer_count = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: floor, ceiling, bit patterns, one count under threshold
		queue_group(0, 0, 0, 0, 0);
		queue_group(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX);
		queue_group(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
		queue_group(2726, 2726, 2726, 2725, 2725);
		wait_drained();

		// mean exactly at the threshold reads below range
		write_reg(REG_ZERO_POINT, 32'd43609);
		queue_group(2726, 2726, 2726, 2725, 2725);
		wait_drained();

		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					write_reg(REG_ZERO_POINT, 32'hFFFF_FFFF);
					write_reg(REG_LOG_PER_COUNT, 32'hFFFF_FFFF);
					write_reg(REG_LOG_AT_ZERO, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_ZERO_POINT, 32'd0);
					write_reg(REG_LOG_PER_COUNT, 32'd0);
					write_reg(REG_LOG_AT_ZERO, 32'd0);
				end
				2: begin
					write_reg(REG_ZERO_POINT, 32'h0000_FFFF);
					write_reg(REG_LOG_PER_COUNT, 32'hFF00_0000);
					write_reg(REG_LOG_AT_ZERO, 32'hFFFF_0000);
				end
				default: begin
					w = $urandom_range(1, 24);
					lpc_bits = $urandom & ((32'd1 << w) - 1);
					write_reg(REG_ZERO_POINT, $urandom);
					write_reg(REG_LOG_PER_COUNT, ($urandom & 32'hFF00_0000) | lpc_bits);
					write_reg(REG_LOG_AT_ZERO, ($urandom & 32'hFFFF_0000) |
						$urandom_range(0, 45000));
				end
			endcase
			write_reg(REG_UNUSED, $urandom);
			for (g = 0; g < PHASE_GROUPS; g++) begin
				plan_random_group();
			end
			wait_drained();
		end

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/gsap_pkg.sv
sv/gsap_if.sv
sv/gsap_front.sv
sv/gsap_queue.sv
sv/gsap_back.sv
sv/gas_sensor_average_to_ppm.sv
tb/sv/tb_gas_sensor_average_to_ppm.sv
